// ===== src/firlt_pkg.sv =====
// shared types and constants of the loadable-tap fir filter
// no dependencies; used by the channel interfaces and the top level
package firlt_pkg;

  // width of the coefficient position field of an input item
  localparam int unsigned TAP_INDEX_W = 6;

  // what an input item asks for
  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_PUSH = 1'b1
  } firlt_cmd_e;

endpackage

// ===== src/firlt_if.sv =====
// valid/ready channel interfaces of the loadable-tap fir filter
// depends on firlt_pkg
interface firlt_in_if
  import firlt_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  firlt_cmd_e                    command;
  logic [TAP_INDEX_W-1:0]        tap_index;
  logic signed [SAMPLE_BITS-1:0] value;

  modport source (output valid, output command, output tap_index, output value, input ready);
  modport sink   (input valid, input command, input tap_index, input value, output ready);
endinterface

interface firlt_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered_sample;
  logic                          saturated;

  modport source (output valid, output filtered_sample, output saturated, input ready);
  modport sink   (input valid, input filtered_sample, input saturated, output ready);
endinterface

// ===== src/fir_filter_loadable_taps_top.sv =====
// direct-form fir filter with loadable taps, one shared multiply-accumulate
// depends on firlt_pkg and the channel interfaces in firlt_if.sv

// A load item (command CMD_LOAD) writes one tap into the coefficient memory
// and gives no result; a tap_index at or beyond TAPS is dropped.
// A push item (command CMD_PUSH) writes the sample into the circular delay-line
// memory and then walks all TAPS taps through one multiplier, newest sample
// against tap 0, so a push occupies the block through the accept cycle, the tap
// reads, the drain of the read / multiply / accumulate pipeline, the rounding
// step and the clipping step that writes the output register. Input ready
// is high only while no push is in progress. The sum is exact, rounded half up
// to Q1.(SAMPLE_BITS-1) and saturated, with saturated set when it clipped. The
// result sits in an output register, so the next item is taken while it waits;
// a push that finishes while the previous result is still untaken holds in its
// clipping cycle. The delay line reads as zero after reset through per-entry
// valid bits; every tap must be loaded before the first push.
module fir_filter_loadable_taps_top
  import firlt_pkg::*;
#(
  parameter int unsigned TAPS        = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  firlt_in_if.sink            sample_i,
  firlt_out_if.source         result_o
);

  localparam int unsigned IDX_W  = $clog2(TAPS);
  localparam int unsigned PROD_W = 2 * SAMPLE_BITS;
  localparam int unsigned ACC_W  = PROD_W + IDX_W;
  localparam int unsigned RND_W  = ACC_W + 1;
  localparam int unsigned FRAC   = SAMPLE_BITS - 1;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);
  localparam logic signed [RND_W-1:0] HALF    = RND_W'(1) <<< (FRAC - 1);
  localparam logic signed [RND_W-1:0] OUT_MAX = (RND_W'(1) <<< FRAC) - RND_W'(1);
  localparam logic signed [RND_W-1:0] OUT_MIN = -(RND_W'(1) <<< FRAC);

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_ROUND = 5'b01000,
    ST_CLIP  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // storage
  logic signed [SAMPLE_BITS-1:0] coef_mem [TAPS];
  logic signed [SAMPLE_BITS-1:0] dly_mem  [TAPS];
  logic [TAPS-1:0]               dly_vld_q;   // entry written since reset

  // control registers
  logic [IDX_W-1:0] newest_q, newest_nxt;     // slot of the newest sample
  logic [IDX_W-1:0] tap_q;                    // tap being read
  logic [IDX_W-1:0] rp_q;                     // delay slot being read
  logic             rd_vld_q, prod_vld_q;

  // datapath registers
  logic signed [SAMPLE_BITS-1:0] coef_rd_q, dly_rd_q;
  logic                          dly_rv_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic signed [RND_W-1:0]       rnd_q;

  // output register
  logic                          out_vld_q;
  logic signed [SAMPLE_BITS-1:0] out_smp_q;
  logic                          out_sat_q;

  logic                     in_fire, push_fire, load_fire, load_ok;
  logic [31:0]              tap_ext;
  logic                     out_free;
  logic signed [SAMPLE_BITS-1:0] dly_op;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [RND_W-1:0]  shf;
  logic signed [SAMPLE_BITS-1:0] clip_smp;
  logic                     clip_sat;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_fire   = sample_i.valid && sample_i.ready;
  assign push_fire = in_fire && (sample_i.command == CMD_PUSH);
  assign load_fire = in_fire && (sample_i.command == CMD_LOAD);

  // loads past the last tap are dropped
  assign tap_ext = 32'(sample_i.tap_index);
  assign load_ok = load_fire && (tap_ext < TAPS);

  assign newest_nxt = (newest_q == LAST_IDX) ? '0 : newest_q + 1'b1;

  // output slot can take a result this cycle
  assign out_free = !out_vld_q || result_o.ready;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (push_fire) state_d = ST_ISSUE;
      ST_ISSUE: if (tap_q == LAST_IDX) state_d = ST_DRAIN;
      ST_DRAIN: if (!rd_vld_q && !prod_vld_q) state_d = ST_ROUND;
      ST_ROUND: state_d = ST_CLIP;
      ST_CLIP:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      newest_q   <= '0;
      tap_q      <= '0;
      rp_q       <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      dly_vld_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= (state_q == ST_ISSUE);
      prod_vld_q <= rd_vld_q;
      if (push_fire) begin
        newest_q              <= newest_nxt;
        rp_q                  <= newest_nxt;
        tap_q                 <= '0;
        dly_vld_q[newest_nxt] <= 1'b1;
      end else if (state_q == ST_ISSUE) begin
        tap_q <= tap_q + 1'b1;
        // walk back from the newest sample, wrapping at slot zero
        rp_q  <= (rp_q == '0) ? LAST_IDX : rp_q - 1'b1;
      end
      if (state_q == ST_CLIP && out_free) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // coefficient memory: written by loads, read once per tap
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      coef_mem[tap_ext[IDX_W-1:0]] <= sample_i.value;
    end
    coef_rd_q <= coef_mem[tap_q];
  end

  // delay-line memory: the write happens in the accept cycle, reads start in the
  // next cycle, so the new sample is already visible at tap 0
  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      dly_mem[newest_nxt] <= sample_i.value;
    end
    dly_rd_q <= dly_mem[rp_q];
    dly_rv_q <= dly_vld_q[rp_q];
  end

  // multiply, then accumulate
  assign dly_op = dly_rv_q ? dly_rd_q : '0;
  assign prod_d = coef_rd_q * dly_op;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (push_fire) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (state_q == ST_ROUND) begin
      rnd_q <= RND_W'(acc_q) + HALF;
    end
  end

  // drop the fraction bits (floor) and clip
  assign shf = rnd_q >>> FRAC;

  always_comb begin
    clip_sat = 1'b0;
    clip_smp = shf[SAMPLE_BITS-1:0];
    if (shf > OUT_MAX) begin
      clip_sat = 1'b1;
      clip_smp = OUT_MAX[SAMPLE_BITS-1:0];
    end else if (shf < OUT_MIN) begin
      clip_sat = 1'b1;
      clip_smp = OUT_MIN[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLIP && out_free) begin
      out_smp_q <= clip_smp;
      out_sat_q <= clip_sat;
    end
  end

  assign result_o.valid           = out_vld_q;
  assign result_o.filtered_sample = out_smp_q;
  assign result_o.saturated       = out_sat_q;

  // a push always starts the tap walk
  a_push_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_fire |=> (state_q == ST_ISSUE))
    else $error("push did not start the tap walk");

  // the multiply pipeline is empty whenever a new item can be taken
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!rd_vld_q && !prod_vld_q))
    else $error("pipeline busy while idle");

  // a clipped result sits at one end of the range
  a_sat_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.saturated) |->
      ((result_o.filtered_sample == OUT_MAX[SAMPLE_BITS-1:0]) ||
       (result_o.filtered_sample == OUT_MIN[SAMPLE_BITS-1:0])))
    else $error("saturated flag without a clipped value");

endmodule

// ===== tb/tb_fir_filter_loadable_taps_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the loadable-tap fir filter top level
// depends on firlt_pkg, the channel interfaces in firlt_if.sv and the top level
module tb_fir_filter_loadable_taps_top;
  import firlt_pkg::*;

  localparam int unsigned TAPS        = 64;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned FRAC_BITS   = SAMPLE_BITS - 1;

  // time one push keeps the block busy while the output side is free
  localparam int unsigned PUSH_CYCLES    = TAPS + 6;
  localparam int unsigned DRAIN_CYCLES   = 2 * PUSH_CYCLES;
  localparam int unsigned HOLD_CYCLES    = 400;
  // worst quiet stretch is the long output hold plus one push, taken well over
  localparam int unsigned WATCHDOG_LIMIT = 4 * (HOLD_CYCLES + PUSH_CYCLES);
  localparam int unsigned RANDOM_ITEMS   = 1220;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned IDLE_PERCENT   = 20;

  localparam longint OUT_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_MIN = -(longint'(1) <<< (SAMPLE_BITS - 1));

  localparam logic signed [SAMPLE_BITS-1:0] Q_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] Q_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] Q_HALF = {2'b01, {(SAMPLE_BITS-2){1'b0}}};

  // one filter output as the block should deliver it
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sat;
  } fir_out_t;

  logic clk_i;
  logic rst_ni;

  firlt_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) sample_if ();
  firlt_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_if ();

  fir_filter_loadable_taps_top #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if)
  );

  // shadow copy of the filter state, updated when an item is accepted
  logic signed [SAMPLE_BITS-1:0] shadow_delay [TAPS];
  logic signed [SAMPLE_BITS-1:0] shadow_taps  [TAPS];
  int unsigned                   shadow_newest;

  // outputs still owed by the block, oldest first
  fir_out_t awaited_outputs [$];

  // shared knobs: random idling on both sides, and a forced output hold-off
  bit          idle_en;
  int unsigned hold_cycles;

  int unsigned fail_count;
  int unsigned n_loads;
  int unsigned n_pushes;
  int unsigned n_outputs;
  int unsigned n_saturated;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // fold one accepted item into the shadow state; a push queues the filter
  // output it must produce: exact sum, round half up, clip to Q1.15
  function automatic void run_fir_item(firlt_cmd_e                    cmd,
                                       logic [TAP_INDEX_W-1:0]        idx,
                                       logic signed [SAMPLE_BITS-1:0] val);
    longint      acc;
    longint      rounded;
    fir_out_t    res;
    int unsigned k;
    if (cmd == CMD_LOAD) begin
      // positions at or beyond TAPS are dropped by the block
      if (idx < TAPS) shadow_taps[idx] = val;
      n_loads++;
      return;
    end
    n_pushes++;
    shadow_newest = (shadow_newest + 1) % TAPS;
    shadow_delay[shadow_newest] = val;
    acc = 0;
    // newest sample meets tap 0, the one pushed k items ago meets tap k
    for (k = 0; k < TAPS; k++) begin
      acc += longint'(shadow_delay[(shadow_newest + TAPS - k) % TAPS]) *
             longint'(shadow_taps[k]);
    end
    // arithmetic shift is a floor, so adding half an lsb rounds ties upward
    rounded = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    res.sat = 1'b0;
    if (rounded > OUT_MAX) begin
      rounded = OUT_MAX;
      res.sat = 1'b1;
    end else if (rounded < OUT_MIN) begin
      rounded = OUT_MIN;
      res.sat = 1'b1;
    end
    res.sample = SAMPLE_BITS'(rounded);
    awaited_outputs.push_back(res);
  endfunction

  // random value, usually scaled down so sums stay inside range, now and
  // then a full-scale extreme
  function automatic logic signed [SAMPLE_BITS-1:0] rand_value(int unsigned shift);
    logic signed [SAMPLE_BITS-1:0] v;
    case ($urandom_range(15))
      0: v = Q_MIN;
      1: v = Q_MAX;
      default: v = $signed(SAMPLE_BITS'($urandom)) >>> shift;
    endcase
    return v;
  endfunction

  // offer one item, with random gaps ahead of it, and hold it until taken
  task automatic send_item(firlt_cmd_e                    cmd,
                           logic [TAP_INDEX_W-1:0]        idx,
                           logic signed [SAMPLE_BITS-1:0] val);
    while (idle_en && $urandom_range(99) < IDLE_PERCENT) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid     <= 1'b1;
    sample_if.command   <= cmd;
    sample_if.tap_index <= idx;
    sample_if.value     <= val;
    do @(posedge clk_i); while (!sample_if.ready);
    run_fir_item(cmd, idx, val);
  endtask

  // drop valid and wait until every owed output has come back
  task automatic wait_drained();
    sample_if.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_outputs.size() != 0) @(posedge clk_i);
  endtask

  // every tap must be written before the first push; all positions get zero
  task automatic test_load_all_taps();
    int unsigned k;
    for (k = 0; k < TAPS; k++) send_item(CMD_LOAD, TAP_INDEX_W'(k), '0);
    // all-zero taps: any sample gives zero
    send_item(CMD_PUSH, '1, Q_MIN);
    send_item(CMD_PUSH, '0, Q_MAX);
    wait_drained();
  endtask

  // tap 0 at one half: odd samples land exactly on a rounding tie
  task automatic test_rounding_ties();
    send_item(CMD_LOAD, '0, Q_HALF);
    send_item(CMD_PUSH, '0, 16'sd1);    // +0.5 lsb rounds up to 1
    send_item(CMD_PUSH, '0, -16'sd1);   // -0.5 lsb rounds up to 0
    send_item(CMD_PUSH, '0, 16'sd3);    // +1.5 lsb -> 2
    send_item(CMD_PUSH, '0, -16'sd3);   // -1.5 lsb -> -1
    send_item(CMD_PUSH, '0, Q_MAX);
    wait_drained();
  endtask

  // full-scale taps and samples drive the sum past both ends of the range
  task automatic test_saturation();
    send_item(CMD_LOAD, '0, Q_MIN);
    send_item(CMD_LOAD, 6'd1, Q_MIN);
    send_item(CMD_LOAD, '1, Q_MAX);     // highest tap position
    send_item(CMD_PUSH, '0, Q_MIN);     // -1 * -1 at tap 0, offset by tap 1
    send_item(CMD_PUSH, '0, Q_MIN);     // -1 * -1 on both taps clips at the top
    send_item(CMD_PUSH, '0, Q_MAX);     // back near zero
    send_item(CMD_PUSH, '0, Q_MAX);     // clips at the bottom
    wait_drained();
  endtask

  // output side stalls long while pushes keep coming, so the result
  // register and the last finished push fill up and input ready drops
  task automatic test_output_backpressure();
    int unsigned k;
    hold_cycles = HOLD_CYCLES;
    for (k = 0; k < 6; k++) send_item(CMD_PUSH, TAP_INDEX_W'($urandom), rand_value(2));
    wait_drained();
  endtask

  // blocks of tap reloads at a random scale followed by bursts of pushes,
  // with stray loads mixed into the bursts
  task automatic test_random_filtering();
    int unsigned sent;
    int unsigned burst;
    int unsigned k;
    int unsigned tap_shift;
    int unsigned samp_shift;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // one stretch in the middle runs with neither side idling
      idle_en = !(sent >= 400 && sent < 700);
      tap_shift = $urandom_range(12);
      if ($urandom_range(3) == 0) begin
        for (k = 0; k < TAPS; k++) send_item(CMD_LOAD, TAP_INDEX_W'(k), rand_value(tap_shift));
        sent += TAPS;
      end else begin
        burst = $urandom_range(16, 1);
        for (k = 0; k < burst; k++)
          send_item(CMD_LOAD, TAP_INDEX_W'($urandom), rand_value(tap_shift));
        sent += burst;
      end
      burst      = $urandom_range(40, 8);
      samp_shift = $urandom_range(8);
      for (k = 0; k < burst; k++) begin
        if ($urandom_range(99) < 8)
          send_item(CMD_LOAD, TAP_INDEX_W'($urandom), rand_value(tap_shift));
        else
          send_item(CMD_PUSH, TAP_INDEX_W'($urandom), rand_value(samp_shift));
      end
      sent += burst;
      // sender occasionally waits for the block to empty completely
      if ($urandom_range(9) == 0) wait_drained();
    end
    idle_en = 1'b1;
    wait_drained();
  endtask

  // output side: check each taken result, then pick ready for the next cycle
  initial begin : result_sink
    fir_out_t want;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_if.valid && result_if.ready) begin
        n_outputs++;
        if (result_if.saturated) n_saturated++;
        if (awaited_outputs.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected output %0d sat %0b at %0t",
                     result_if.filtered_sample, result_if.saturated, $realtime);
        end else begin
          want = awaited_outputs.pop_front();
          if (result_if.filtered_sample !== want.sample ||
              result_if.saturated !== want.sat) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("output %0d mismatch: expected %0d sat %0b, got %0d sat %0b",
                       n_outputs, want.sample, want.sat,
                       result_if.filtered_sample, result_if.saturated);
          end
        end
      end
      if (hold_cycles > 0) begin
        result_if.ready <= 1'b0;
        hold_cycles--;
      end else if (idle_en) begin
        result_if.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // ends the run when no item moves on either side for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : main_sequence
    int unsigned k;
    for (k = 0; k < TAPS; k++) begin
      shadow_delay[k] = '0;
      shadow_taps[k]  = '0;
    end
    shadow_newest = 0;
    idle_en       = 1'b1;
    hold_cycles   = 0;
    fail_count    = 0;
    n_loads       = 0;
    n_pushes      = 0;
    n_outputs     = 0;
    n_saturated   = 0;

    rst_ni              <= 1'b0;
    sample_if.valid     <= 1'b0;
    sample_if.command   <= CMD_LOAD;
    sample_if.tap_index <= '0;
    sample_if.value     <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_load_all_taps();
    test_rounding_ties();
    test_saturation();
    test_output_backpressure();
    test_random_filtering();

    // let any stray output show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (awaited_outputs.size() != 0) begin
      fail_count++;
      $display("%0d outputs never arrived", awaited_outputs.size());
    end

    $display("covered %0d tap loads and %0d sample pushes; %0d outputs checked, %0d clipped",
             n_loads, n_pushes, n_outputs, n_saturated);
    $display("included rounding ties, both clip limits, a long output stall, %0d failures",
             fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
